@@ rtl/concept_keyword_lexer_unit_defines.svh @@
// assertion helpers shared by the lexer modules
`ifndef CONCEPT_KEYWORD_LEXER_UNIT_DEFINES_SVH
`define CONCEPT_KEYWORD_LEXER_UNIT_DEFINES_SVH

// antecedent implies consequent on every clock, off during reset
`define CKL_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// expression must never hold outside reset
`define CKL_ASSERT_NEVER(label, expr, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) !(expr)) \
    else $error(msg);

`endif

@@ rtl/ckl_pkg.sv @@
package ckl_pkg;

  localparam int QUEUE_DEPTH = 4;

  localparam logic [4:0] KIND_EOS     = 5'd0;
  localparam logic [4:0] KIND_SEMI    = 5'd1;
  localparam logic [4:0] KIND_LPAR    = 5'd2;
  localparam logic [4:0] KIND_RPAR    = 5'd3;
  localparam logic [4:0] KIND_AND     = 5'd4;
  localparam logic [4:0] KIND_ANYTH   = 5'd5;
  localparam logic [4:0] KIND_SOME    = 5'd6;
  localparam logic [4:0] KIND_SOMETH  = 5'd7;
  localparam logic [4:0] KIND_OR      = 5'd8;
  localparam logic [4:0] KIND_ONLY    = 5'd9;
  localparam logic [4:0] KIND_NOT     = 5'd10;
  localparam logic [4:0] KIND_NOTH    = 5'd11;
  localparam logic [4:0] KIND_IN      = 5'd12;
  localparam logic [4:0] KIND_IS      = 5'd13;
  localparam logic [4:0] KIND_ISA     = 5'd14;
  localparam logic [4:0] KIND_TRANS   = 5'd15;
  localparam logic [4:0] KIND_IDENT   = 5'd16;
  localparam logic [4:0] KIND_INVALID = 5'd17;

  typedef struct packed {
    logic [4:0] kind;
    logic [7:0] len;
  } ckl_tok_t;

  // all tokens caused by one input beat: first token, optional second
  typedef struct packed {
    ckl_tok_t tok0;
    ckl_tok_t tok1;
    logic     two;
  } ckl_rec_t;

endpackage

@@ rtl/ckl_front.sv @@
module ckl_front import ckl_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [7:0] character_i,
  input  logic       end_of_stream_i,
  input  logic       full_i,
  output logic       push_o,
  output ckl_rec_t   push_rec_o
);

  localparam logic [5:0] POS_IDLE  = 6'd0;
  localparam logic [5:0] POS_IDENT = 6'd1;

  function automatic logic is_ident(input logic [7:0] c);
    return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") ||
           (c >= "0" && c <= "9") || c == "_";
  endfunction

  // keyword trie: position is 2 + node index, plain identifier otherwise
  function automatic logic [5:0] trie_advance(input logic [5:0] pos, input logic [7:0] c);
    logic [5:0] nxt;
    nxt = POS_IDENT;
    case (pos)
      POS_IDLE: begin
        case (c)
          "a": nxt = 6'd2;
          "s": nxt = 6'd11;
          "o": nxt = 6'd20;
          "n": nxt = 6'd25;
          "i": nxt = 6'd32;
          "t": nxt = 6'd36;
          default: nxt = POS_IDENT;
        endcase
      end
      6'd2:  if (c == "n") nxt = 6'd3;
      6'd3: begin
        if (c == "d") nxt = 6'd4;
        else if (c == "y") nxt = 6'd5;
      end
      6'd5:  if (c == "t") nxt = 6'd6;
      6'd6:  if (c == "h") nxt = 6'd7;
      6'd7:  if (c == "i") nxt = 6'd8;
      6'd8:  if (c == "n") nxt = 6'd9;
      6'd9:  if (c == "g") nxt = 6'd10;
      6'd11: if (c == "o") nxt = 6'd12;
      6'd12: if (c == "m") nxt = 6'd13;
      6'd13: if (c == "e") nxt = 6'd14;
      6'd14: if (c == "t") nxt = 6'd15;
      6'd15: if (c == "h") nxt = 6'd16;
      6'd16: if (c == "i") nxt = 6'd17;
      6'd17: if (c == "n") nxt = 6'd18;
      6'd18: if (c == "g") nxt = 6'd19;
      6'd20: begin
        if (c == "r") nxt = 6'd21;
        else if (c == "n") nxt = 6'd22;
      end
      6'd22: if (c == "l") nxt = 6'd23;
      6'd23: if (c == "y") nxt = 6'd24;
      6'd25: if (c == "o") nxt = 6'd26;
      6'd26: if (c == "t") nxt = 6'd27;
      6'd27: if (c == "h") nxt = 6'd28;
      6'd28: if (c == "i") nxt = 6'd29;
      6'd29: if (c == "n") nxt = 6'd30;
      6'd30: if (c == "g") nxt = 6'd31;
      6'd32: begin
        if (c == "n") nxt = 6'd33;
        else if (c == "s") nxt = 6'd34;
      end
      6'd34: if (c == "a") nxt = 6'd35;
      6'd36: if (c == "r") nxt = 6'd37;
      6'd37: if (c == "a") nxt = 6'd38;
      6'd38: if (c == "n") nxt = 6'd39;
      6'd39: if (c == "s") nxt = 6'd40;
      default: nxt = POS_IDENT;
    endcase
    return nxt;
  endfunction

  function automatic logic [4:0] pos_kind(input logic [5:0] pos);
    logic [4:0] k;
    case (pos)
      6'd4:    k = KIND_AND;
      6'd10:   k = KIND_ANYTH;
      6'd14:   k = KIND_SOME;
      6'd19:   k = KIND_SOMETH;
      6'd21:   k = KIND_OR;
      6'd24:   k = KIND_ONLY;
      6'd27:   k = KIND_NOT;
      6'd31:   k = KIND_NOTH;
      6'd33:   k = KIND_IN;
      6'd34:   k = KIND_IS;
      6'd35:   k = KIND_ISA;
      6'd40:   k = KIND_TRANS;
      default: k = KIND_IDENT;
    endcase
    return k;
  endfunction

  logic [5:0] pos_q, pos_d;
  logic [7:0] len_q, len_d;
  logic       err_q, err_d;

  logic       accept;
  logic       have_run;
  logic       delim_tok;
  ckl_tok_t   run_tok, dl_tok;

  assign in_ready_o = !full_i;
  assign accept     = in_valid_i && in_ready_o;
  assign have_run   = (pos_q != POS_IDLE);
  assign run_tok    = '{kind: pos_kind(pos_q), len: len_q};

  always_comb begin
    pos_d      = pos_q;
    len_d      = len_q;
    err_d      = err_q;
    push_o     = 1'b0;
    push_rec_o = '0;
    delim_tok  = 1'b0;
    dl_tok     = '{kind: KIND_INVALID, len: 8'd1};
    if (accept) begin
      if (end_of_stream_i) begin
        push_o = 1'b1;
        if (!err_q && have_run) begin
          push_rec_o.tok0 = run_tok;
          push_rec_o.tok1 = '{kind: KIND_EOS, len: 8'd0};
          push_rec_o.two  = 1'b1;
        end else begin
          push_rec_o.tok0 = '{kind: KIND_EOS, len: 8'd0};
        end
        pos_d = POS_IDLE;
        len_d = '0;
        err_d = 1'b0;
      end else if (!err_q) begin
        if (is_ident(character_i)) begin
          pos_d = trie_advance(pos_q, character_i);
          if (len_q != 8'hFF) len_d = len_q + 8'd1;
        end else begin
          pos_d = POS_IDLE;
          len_d = '0;
          case (character_i)
            " ", "\t", "\n", 8'h00, 8'hFF: delim_tok = 1'b0;
            ";": begin
              delim_tok   = 1'b1;
              dl_tok.kind = KIND_SEMI;
            end
            "(": begin
              delim_tok   = 1'b1;
              dl_tok.kind = KIND_LPAR;
            end
            ")": begin
              delim_tok   = 1'b1;
              dl_tok.kind = KIND_RPAR;
            end
            default: begin
              delim_tok = 1'b1;
              err_d     = 1'b1;
            end
          endcase
          push_o = have_run || delim_tok;
          if (have_run) begin
            push_rec_o.tok0 = run_tok;
            push_rec_o.tok1 = dl_tok;
            push_rec_o.two  = delim_tok;
          end else begin
            push_rec_o.tok0 = dl_tok;
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q <= POS_IDLE;
      len_q <= '0;
      err_q <= 1'b0;
    end else begin
      pos_q <= pos_d;
      len_q <= len_d;
      err_q <= err_d;
    end
  end

endmodule

@@ rtl/ckl_queue.sv @@
`include "concept_keyword_lexer_unit_defines.svh"

module ckl_queue import ckl_pkg::*; #(
  parameter int Depth = QUEUE_DEPTH
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     push_i,
  input  ckl_rec_t push_rec_i,
  output logic     full_o,
  input  logic     pop_i,
  output logic     valid_o,
  output ckl_rec_t pop_rec_o
);

  localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(Depth - 1);
  localparam logic [CntW-1:0] FullCnt = CntW'(Depth);

  ckl_rec_t        mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0] cnt_q;
  logic            do_pop;

  assign full_o    = (cnt_q == FullCnt);
  assign valid_o   = (cnt_q != '0);
  assign pop_rec_o = mem_q[rd_ptr_q];
  assign do_pop    = pop_i && valid_o;

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wr_ptr_q] <= push_rec_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push_i) wr_ptr_q <= (wr_ptr_q == LastPtr) ? '0 : wr_ptr_q + 1'b1;
      if (do_pop) rd_ptr_q <= (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + 1'b1;
      if (push_i && !do_pop) cnt_q <= cnt_q + 1'b1;
      else if (!push_i && do_pop) cnt_q <= cnt_q - 1'b1;
    end
  end

  `CKL_ASSERT_NEVER(a_no_push_full, push_i && full_o, "push into full token queue")
  `CKL_ASSERT_NEVER(a_cnt_range, cnt_q > FullCnt, "token queue count overflow")
  `CKL_ASSERT_IMP(a_ptr_gap, cnt_q == '0, wr_ptr_q == rd_ptr_q, "empty queue with pointer gap")

endmodule

@@ rtl/ckl_back.sv @@
`include "concept_keyword_lexer_unit_defines.svh"

module ckl_back import ckl_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       q_valid_i,
  input  ckl_rec_t   q_rec_i,
  output logic       pop_o,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [4:0] token_kind_o,
  output logic [7:0] token_length_o,
  output logic       last_of_step_o
);

  ckl_rec_t rec_q;
  logic     hold_q;
  logic     phase_q;   // 0 shows first token, 1 shows second
  logic     out_beat;
  logic     done;

  assign out_valid_o    = hold_q;
  assign out_beat       = hold_q && out_ready_i;
  assign last_of_step_o = !rec_q.two || phase_q;
  assign done           = out_beat && last_of_step_o;
  assign pop_o          = q_valid_i && (!hold_q || done);
  assign token_kind_o   = phase_q ? rec_q.tok1.kind : rec_q.tok0.kind;
  assign token_length_o = phase_q ? rec_q.tok1.len : rec_q.tok0.len;

  always_ff @(posedge clk_i) begin
    if (pop_o) rec_q <= q_rec_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hold_q  <= 1'b0;
      phase_q <= 1'b0;
    end else if (pop_o) begin
      hold_q  <= 1'b1;
      phase_q <= 1'b0;
    end else if (done) begin
      hold_q  <= 1'b0;
      phase_q <= 1'b0;
    end else if (out_beat) begin
      phase_q <= 1'b1;
    end
  end

  `CKL_ASSERT_IMP(a_phase_two, phase_q, hold_q && rec_q.two, "second token without pair")
  `CKL_ASSERT_IMP(a_pair_next, out_beat && !last_of_step_o, ##1 (hold_q && phase_q),
                  "second token of pair lost")
  `CKL_ASSERT_IMP(a_eos_last, hold_q && token_kind_o == KIND_EOS, last_of_step_o,
                  "eos token not last of beat")

endmodule

@@ rtl/concept_keyword_lexer_unit.sv @@
// concept keyword lexer
// input channel: one byte per beat on character_i, or an end-of-stream mark
//   on end_of_stream_i (byte ignored then), handshake in_valid_i / in_ready_o
// output channel: one token per beat (token_kind_o, token_length_o,
//   last_of_step_o), handshake out_valid_o / out_ready_i
// a byte gives zero, one or two tokens; last_of_step_o flags the final one
// throughput: one input byte per cycle while the output keeps up; a byte that
//   closes a run and is itself a token needs two output beats
// out_valid_o comes from the back register, which loads from the token queue;
//   the front writes the queue at the accepting edge
// a queue of QueueDepth entries sits between front and back; when the
//   receiver stalls, the front keeps lexing until the queue fills, then
//   in_ready_o drops; tokens already made are held and never dropped
// after an invalid byte all input up to end of stream is discarded
// reset: lexer idle between tokens, error cleared, queue and output empty
module concept_keyword_lexer_unit import ckl_pkg::*; #(
  parameter int QueueDepth = QUEUE_DEPTH
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [7:0] character_i,
  input  logic       end_of_stream_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [4:0] token_kind_o,
  output logic [7:0] token_length_o,
  output logic       last_of_step_o
);

  logic     full, push, pop, q_valid;
  ckl_rec_t push_rec, pop_rec;

  ckl_front u_front (
    .clk_i,
    .rst_ni,
    .in_valid_i,
    .in_ready_o,
    .character_i,
    .end_of_stream_i,
    .full_i     (full),
    .push_o     (push),
    .push_rec_o (push_rec)
  );

  ckl_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i,
    .rst_ni,
    .push_i     (push),
    .push_rec_i (push_rec),
    .full_o     (full),
    .pop_i      (pop),
    .valid_o    (q_valid),
    .pop_rec_o  (pop_rec)
  );

  ckl_back u_back (
    .clk_i,
    .rst_ni,
    .q_valid_i  (q_valid),
    .q_rec_i    (pop_rec),
    .pop_o      (pop),
    .out_valid_o,
    .out_ready_i,
    .token_kind_o,
    .token_length_o,
    .last_of_step_o
  );

endmodule
